>>> hdl/kpdu_pkg.sv
// Shared types, constants and the nibble character table for the keyed
// packet decrypt and unpack block. No dependencies.
package kpdu_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [BYTE_W-1:0] FIRST_SUB  = 8'h0F;
    localparam logic [BYTE_W-1:0] KEY_BIAS   = 8'h40;
    localparam logic [BYTE_W-1:0] XOR_MASK   = 8'hC3;
    localparam logic [BYTE_W-1:0] END_MARK   = 8'hFF;
    localparam logic [BYTE_W-1:0] RAW_MASK   = 8'hFF;

    // Transform variants picked by key bits 7:6
    typedef enum logic [1:0] {
        XF_DIFF     = 2'd0,
        XF_SUM      = 2'd1,
        XF_DIFF_XOR = 2'd2,
        XF_SUM_XOR  = 2'd3
    } t_xform;

    // One queue entry: the one or two results caused by one request
    typedef struct packed {
        logic [BYTE_W-1:0] ch_a;     // first character
        logic [BYTE_W-1:0] ch_b;     // second character, packed bytes only
        logic              two;      // entry carries two results
        logic              valid_a;  // first result carries a character
        logic              end_last; // last result ends the packet
    } t_entry;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Nibble to character lookup
    function automatic logic [BYTE_W-1:0] nibble_char(input logic [3:0] nib);
        logic [BYTE_W-1:0] ch;
        unique case (nib)
            4'h0:    ch = 8'h00;
            4'h1:    ch = 8'h20;
            4'h2:    ch = 8'h2D;
            4'h3:    ch = 8'h2E;
            4'h4:    ch = 8'h30;
            4'h5:    ch = 8'h31;
            4'h6:    ch = 8'h32;
            4'h7:    ch = 8'h33;
            4'h8:    ch = 8'h34;
            4'h9:    ch = 8'h35;
            4'hA:    ch = 8'h36;
            4'hB:    ch = 8'h37;
            4'hC:    ch = 8'h38;
            4'hD:    ch = 8'h39;
            4'hE:    ch = 8'hFF;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> hdl/kpdu_front.sv
// Front end: decrypts each request, tracks chunk state and classifies the
// request, turning one that has a result into a queue entry. Depends on kpdu_pkg.
module kpdu_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [kpdu_pkg::BYTE_W-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [kpdu_pkg::BYTE_W-1:0] i_cipher_byte,
    input  logic                     i_first_packet,
    input  kpdu_pkg::t_q_stat        i_q_stat,
    output logic                     o_push,
    output kpdu_pkg::t_entry         o_entry
);
    import kpdu_pkg::*;

    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_RAW    = 2'd1,
        MODE_PACKED = 2'd2
    } t_mode;

    logic [BYTE_W-1:0]  r_key;
    t_mode              r_mode, n_mode;
    logic [COUNT_W-1:0] r_left, n_left;

    logic [BYTE_W-1:0]  sum, diff, plain;
    logic               is_end, accept, has_result;
    logic [COUNT_W-1:0] left_dec;
    logic [COUNT_W:0]   half_cnt;
    t_entry             entry;

    assign o_in_ready = !i_q_stat.full;
    assign accept     = i_in_valid && o_in_ready;

    // Decrypt the cipher byte
    always_comb begin
        sum  = i_cipher_byte + r_key + KEY_BIAS;
        diff = i_cipher_byte - r_key - KEY_BIAS;
        unique case (t_xform'(r_key[7:6]))
            XF_DIFF:     plain = diff;
            XF_SUM:      plain = sum;
            XF_DIFF_XOR: plain = diff ^ XOR_MASK;
            XF_SUM_XOR:  plain = sum ^ XOR_MASK;
            default:     plain = diff;
        endcase
        if (i_first_packet) begin
            plain = i_cipher_byte - FIRST_SUB;
        end
    end

    // Classify the request and compute next chunk state
    always_comb begin
        is_end     = (plain == END_MARK);
        left_dec   = r_left - COUNT_W'(1);
        half_cnt   = ({1'b0, plain[COUNT_W-1:0]} + (COUNT_W+1)'(1)) >> 1;
        n_mode     = r_mode;
        n_left     = r_left;
        has_result = 1'b0;
        entry      = '0;
        unique case (r_mode)
            MODE_RAW: begin
                has_result     = 1'b1;
                entry.ch_a     = plain ^ RAW_MASK;
                entry.valid_a  = 1'b1;
                entry.end_last = is_end;
                n_left         = left_dec;
                if (left_dec == '0) begin
                    n_mode = MODE_HEADER;
                end
            end
            MODE_PACKED: begin
                has_result     = 1'b1;
                entry.ch_a     = nibble_char(plain[7:4]);
                entry.ch_b     = nibble_char(plain[3:0]);
                entry.valid_a  = 1'b1;
                entry.end_last = is_end;
                if (plain[3:0] == 4'h0) begin
                    n_mode = MODE_HEADER;
                    n_left = '0;
                end else begin
                    entry.two = 1'b1;
                    n_left    = left_dec;
                    if (left_dec == '0) begin
                        n_mode = MODE_HEADER;
                    end
                end
            end
            default: begin
                if (is_end) begin
                    has_result     = 1'b1;
                    entry.end_last = 1'b1;
                end else if (plain[7]) begin
                    n_left = half_cnt[COUNT_W-1:0];
                    n_mode = (half_cnt == '0) ? MODE_HEADER : MODE_PACKED;
                end else begin
                    n_left = plain[COUNT_W-1:0];
                    n_mode = (plain[COUNT_W-1:0] == '0) ? MODE_HEADER : MODE_RAW;
                end
            end
        endcase
        // End marker always returns to header
        if (is_end) begin
            n_mode = MODE_HEADER;
            n_left = '0;
        end
    end

    assign o_push  = accept && has_result;
    assign o_entry = entry;

    // Hold key and chunk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_mode <= MODE_HEADER;
            r_left <= '0;
        end else begin
            if (i_cfg_we) begin
                r_key <= i_cfg_data;
            end
            if (accept) begin
                r_mode <= n_mode;
                r_left <= n_left;
            end
        end
    end

endmodule

>>> hdl/kpdu_queue.sv
// Short entry queue between front and back ends.
// Depends on kpdu_pkg.
module kpdu_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  kpdu_pkg::t_entry  i_entry,
    input  logic              i_pop,
    output kpdu_pkg::t_entry  o_head,
    output kpdu_pkg::t_q_stat o_stat
);
    import kpdu_pkg::*;

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push, do_pop;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rp];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

endmodule

>>> hdl/kpdu_back.sv
// Back end: streams the results of each queue entry, one per cycle while the
// output is not stalled, into the output register. Depends on kpdu_pkg.
module kpdu_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kpdu_pkg::t_entry            i_head,
    input  kpdu_pkg::t_q_stat           i_q_stat,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [kpdu_pkg::BYTE_W-1:0] o_char_out,
    output logic                        o_char_valid,
    output logic                        o_packet_end
);
    import kpdu_pkg::*;

    logic              r_valid;
    logic              r_sel;
    logic [BYTE_W-1:0] r_char;
    logic              r_cvalid;
    logic              r_end;
    logic              load;

    assign load  = (!r_valid || i_out_ready) && !i_q_stat.empty;
    assign o_pop = load && (r_sel || !i_head.two);

    // Control: output valid and result select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= !r_sel && i_head.two;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload: load the selected result
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_sel) begin
                r_char   <= i_head.ch_b;
                r_cvalid <= 1'b1;
                r_end    <= i_head.end_last;
            end else begin
                r_char   <= i_head.ch_a;
                r_cvalid <= i_head.valid_a;
                r_end    <= i_head.end_last && !i_head.two;
            end
        end
    end

    assign o_out_valid  = r_valid;
    assign o_char_out   = r_char;
    assign o_char_valid = r_cvalid;
    assign o_packet_end = r_end;

endmodule

>>> hdl/keyed_packet_decrypt_unpack_core.sv
// Keyed packet decrypt and chunk unpack, top level.
// A request's results pass through the two-entry queue and then the output register.
// Requests are taken one per cycle while the queue is not full; the output register
// sends one result per cycle while not stalled, so a packed byte with two results uses it twice.
// Reset (i_rst_n low, synchronous): key cleared, unpacker expects a header,
// queue and output register empty.
module keyed_packet_decrypt_unpack_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [kpdu_pkg::BYTE_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [kpdu_pkg::BYTE_W-1:0] i_cipher_byte,
    input  logic                        i_first_packet,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [kpdu_pkg::BYTE_W-1:0] o_char_out,
    output logic                        o_char_valid,
    output logic                        o_packet_end
);
    import kpdu_pkg::*;

    t_entry  push_entry, head;
    t_q_stat q_stat;
    logic    push, pop;

    kpdu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cipher_byte  (i_cipher_byte),
        .i_first_packet (i_first_packet),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    kpdu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    kpdu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_char_out   (o_char_out),
        .o_char_valid (o_char_valid),
        .o_packet_end (o_packet_end)
    );

endmodule

>>> hdl/kpdu_checker.sv
// Port-level checks for the decrypt and unpack top level, with its bind.
// Depends on kpdu_pkg.
module kpdu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [kpdu_pkg::BYTE_W-1:0] i_cipher_byte,
    input logic                        i_first_packet,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [kpdu_pkg::BYTE_W-1:0] o_char_out,
    input logic                        o_char_valid,
    input logic                        o_packet_end
);
    import kpdu_pkg::*;

    // Hold a waiting request unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_cipher_byte) && $stable(i_first_packet))
        else $error("request changed while waiting");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_char_out) && $stable(o_char_valid) && $stable(o_packet_end))
        else $error("result changed while stalled");

    // A bare marker only ever closes a packet
    a_bare_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_char_valid |-> o_packet_end && (o_char_out == '0))
        else $error("bare result without packet end");

    // The end marker always decodes to a zero character
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_end |-> (o_char_out == '0))
        else $error("packet end with nonzero character");

endmodule

bind keyed_packet_decrypt_unpack_core kpdu_checker u_kpdu_checker (.*);
